/* src/kcht_pkg.sv */
// Shared types and constants for the keyed chained hash table.
// Used by the controller and the top level; depends on nothing.

package kcht_pkg;

   localparam int BUCKETS = 64;
   localparam int ENTRIES = 256;

   localparam int BKT_W  = $clog2(BUCKETS);
   localparam int ADDR_W = $clog2(ENTRIES);
   localparam int IDX_W  = $clog2(ENTRIES + 1);

   localparam int ACT_W = 2;
   localparam int PID_W = 20;
   localparam int TID_W = 31;
   localparam int VAL_W = 32;
   localparam int STS_W = 2;
   localparam int KEY_W = PID_W + TID_W + VAL_W;

   localparam int REQ_DATA_W = ((PID_W + TID_W + VAL_W + 7) / 8) * 8;
   localparam int RSP_DATA_W = VAL_W;

   // The null link is the first index past the pool.
   localparam logic [IDX_W-1:0] NIL = IDX_W'(ENTRIES);

   typedef enum logic [ACT_W-1:0] {
      ACT_ADD    = 2'd0,
      ACT_REMOVE = 2'd1,
      ACT_LOOKUP = 2'd2,
      ACT_CHECK  = 2'd3
   } action_type;

   typedef enum logic [STS_W-1:0] {
      STS_OK   = 2'd0,
      STS_MISS = 2'd1,
      STS_FULL = 2'd2
   } status_type;

   typedef struct packed {
      logic              rd_en;
      logic [BKT_W-1:0]  rd_addr;
      logic              wr_en;
      logic [BKT_W-1:0]  wr_addr;
      logic [IDX_W-1:0]  wr_data;
   } head_port_type;

   typedef struct packed {
      logic              rd_en;
      logic [ADDR_W-1:0] rd_addr;
      logic              wr_en;
      logic [ADDR_W-1:0] wr_addr;
      logic [KEY_W-1:0]  wr_data;
   } key_port_type;

   typedef struct packed {
      logic              rd_en;
      logic [ADDR_W-1:0] rd_addr;
      logic              wr_en;
      logic [ADDR_W-1:0] wr_addr;
      logic [IDX_W-1:0]  wr_data;
   } link_port_type;

endpackage

/* src/kcht_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read data.
// Stand-alone; no package dependency.

module kcht_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* src/kcht_ctrl.sv */
// Sequencer for the hash table: allocation, chain walk, unlink and result register.
// Depends on kcht_pkg; drives the bucket-head, key and link RAM ports.

module kcht_ctrl (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [kcht_pkg::REQ_DATA_W-1:0]     req_tdata,
   input  logic [kcht_pkg::ACT_W-1:0]          req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [kcht_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   output logic [kcht_pkg::STS_W-1:0]          rsp_tuser,
   output kcht_pkg::head_port_type             head_port,
   input  logic [kcht_pkg::IDX_W-1:0]          head_rd_data,
   output kcht_pkg::key_port_type              key_port,
   input  logic [kcht_pkg::KEY_W-1:0]          key_rd_data,
   output kcht_pkg::link_port_type             link_port,
   input  logic [kcht_pkg::IDX_W-1:0]          link_rd_data
);

   localparam int PID_W  = kcht_pkg::PID_W;
   localparam int TID_W  = kcht_pkg::TID_W;
   localparam int VAL_W  = kcht_pkg::VAL_W;
   localparam int BKT_W  = kcht_pkg::BKT_W;
   localparam int ADDR_W = kcht_pkg::ADDR_W;
   localparam int IDX_W  = kcht_pkg::IDX_W;

   typedef enum logic [2:0] {
      S_IDLE,
      S_HEAD,
      S_WALK,
      S_FREE,
      S_RESP
   } state_type;

   state_type                    state_ff, state_in;
   kcht_pkg::action_type         action_ff, action_in;
   logic [PID_W-1:0]             pid_ff, pid_in;
   logic [TID_W-1:0]             tid_ff, tid_in;
   logic [VAL_W-1:0]             val_ff, val_in;
   logic [IDX_W-1:0]             cur_ff, cur_in;
   logic [IDX_W-1:0]             prev_ff, prev_in;
   logic [IDX_W-1:0]             steps_ff, steps_in;
   logic [IDX_W-1:0]             free_head_ff, free_head_in;
   logic [IDX_W-1:0]             fresh_ff, fresh_in;
   logic [kcht_pkg::BUCKETS-1:0] valid_ff, valid_in;
   kcht_pkg::status_type         res_status_ff, res_status_in;
   logic [VAL_W-1:0]             res_value_ff, res_value_in;
   logic                         rsp_tvalid_ff, rsp_tvalid_in;
   kcht_pkg::status_type         rsp_status_ff, rsp_status_in;
   logic [VAL_W-1:0]             rsp_value_ff, rsp_value_in;

   logic [BKT_W-1:0]  bucket;
   logic [IDX_W-1:0]  head_val;
   logic [IDX_W-1:0]  alloc;
   logic              alloc_ok;
   logic [PID_W-1:0]  rd_pid;
   logic [TID_W-1:0]  rd_tid;
   logic [VAL_W-1:0]  rd_val;
   logic              match;
   logic [IDX_W-1:0]  steps_next;

   // The bucket count is a power of two, so the modulo is the low bits.
   assign bucket = pid_ff[BKT_W-1:0];

   assign rd_pid = key_rd_data[PID_W-1:0];
   assign rd_tid = key_rd_data[PID_W+TID_W-1:PID_W];
   assign rd_val = key_rd_data[kcht_pkg::KEY_W-1:PID_W+TID_W];

   assign head_val   = valid_ff[bucket] ? head_rd_data : kcht_pkg::NIL;
   assign match      = (rd_pid == pid_ff) &&
                       ((action_ff == kcht_pkg::ACT_CHECK) || (rd_tid == tid_ff));
   assign steps_next = steps_ff + IDX_W'(1);

   always_comb begin
      state_in      = state_ff;
      action_in     = action_ff;
      pid_in        = pid_ff;
      tid_in        = tid_ff;
      val_in        = val_ff;
      cur_in        = cur_ff;
      prev_in       = prev_ff;
      steps_in      = steps_ff;
      free_head_in  = free_head_ff;
      fresh_in      = fresh_ff;
      valid_in      = valid_ff;
      res_status_in = res_status_ff;
      res_value_in  = res_value_ff;
      rsp_status_in = rsp_status_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_tvalid_in = rsp_tvalid_ff & ~rsp_tready;
      head_port     = '0;
      key_port      = '0;
      link_port     = '0;
      alloc         = kcht_pkg::NIL;
      alloc_ok      = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               action_in = kcht_pkg::action_type'(req_tuser);
               pid_in    = req_tdata[PID_W-1:0];
               tid_in    = req_tdata[PID_W+TID_W-1:PID_W];
               val_in    = req_tdata[PID_W+TID_W+VAL_W-1:PID_W+TID_W];
               head_port.rd_en   = 1'b1;
               head_port.rd_addr = req_tdata[BKT_W-1:0];
               // Fetch the successor of the free-list head in case this is an add.
               link_port.rd_en   = 1'b1;
               link_port.rd_addr = free_head_ff[ADDR_W-1:0];
               state_in = S_HEAD;
            end
         end

         S_HEAD: begin
            res_value_in = '0;
            if (action_ff == kcht_pkg::ACT_ADD) begin
               if (free_head_ff != kcht_pkg::NIL) begin
                  alloc        = free_head_ff;
                  alloc_ok     = 1'b1;
                  free_head_in = link_rd_data;
               end else if (fresh_ff != kcht_pkg::NIL) begin
                  alloc    = fresh_ff;
                  alloc_ok = 1'b1;
                  fresh_in = fresh_ff + IDX_W'(1);
               end
               if (alloc_ok) begin
                  key_port.wr_en    = 1'b1;
                  key_port.wr_addr  = alloc[ADDR_W-1:0];
                  key_port.wr_data  = {val_ff, tid_ff, pid_ff};
                  link_port.wr_en   = 1'b1;
                  link_port.wr_addr = alloc[ADDR_W-1:0];
                  link_port.wr_data = head_val;
                  head_port.wr_en   = 1'b1;
                  head_port.wr_addr = bucket;
                  head_port.wr_data = alloc;
                  valid_in[bucket]  = 1'b1;
                  res_status_in     = kcht_pkg::STS_OK;
               end else begin
                  res_status_in = kcht_pkg::STS_FULL;
               end
               state_in = S_RESP;
            end else begin
               res_status_in = kcht_pkg::STS_MISS;
               prev_in       = kcht_pkg::NIL;
               steps_in      = '0;
               cur_in        = head_val;
               if (head_val == kcht_pkg::NIL) begin
                  state_in = S_RESP;
               end else begin
                  key_port.rd_en    = 1'b1;
                  key_port.rd_addr  = head_val[ADDR_W-1:0];
                  link_port.rd_en   = 1'b1;
                  link_port.rd_addr = head_val[ADDR_W-1:0];
                  state_in = S_WALK;
               end
            end
         end

         S_WALK: begin
            if (match) begin
               res_status_in = kcht_pkg::STS_OK;
               state_in      = S_RESP;
               if (action_ff == kcht_pkg::ACT_LOOKUP) begin
                  res_value_in = rd_val;
               end
               if (action_ff == kcht_pkg::ACT_REMOVE) begin
                  // Bypass the hit entry; it joins the free list next cycle.
                  if (prev_ff != kcht_pkg::NIL) begin
                     link_port.wr_en   = 1'b1;
                     link_port.wr_addr = prev_ff[ADDR_W-1:0];
                     link_port.wr_data = link_rd_data;
                  end else begin
                     head_port.wr_en   = 1'b1;
                     head_port.wr_addr = bucket;
                     head_port.wr_data = link_rd_data;
                  end
                  state_in = S_FREE;
               end
            end else begin
               prev_in  = cur_ff;
               cur_in   = link_rd_data;
               steps_in = steps_next;
               if ((link_rd_data == kcht_pkg::NIL) || (steps_next == kcht_pkg::NIL)) begin
                  state_in = S_RESP;
               end else begin
                  key_port.rd_en    = 1'b1;
                  key_port.rd_addr  = link_rd_data[ADDR_W-1:0];
                  link_port.rd_en   = 1'b1;
                  link_port.rd_addr = link_rd_data[ADDR_W-1:0];
               end
            end
         end

         S_FREE: begin
            link_port.wr_en   = 1'b1;
            link_port.wr_addr = cur_ff[ADDR_W-1:0];
            link_port.wr_data = free_head_ff;
            free_head_in      = cur_ff;
            state_in          = S_RESP;
         end

         S_RESP: begin
            // Wait only if the previous result is still held by the receiver.
            if (!rsp_tvalid_ff || rsp_tready) begin
               rsp_tvalid_in = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_value_in  = res_value_ff;
               state_in      = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         free_head_ff  <= kcht_pkg::NIL;
         fresh_ff      <= '0;
         valid_ff      <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         free_head_ff  <= free_head_in;
         fresh_ff      <= fresh_in;
         valid_ff      <= valid_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
      action_ff     <= action_in;
      pid_ff        <= pid_in;
      tid_ff        <= tid_in;
      val_ff        <= val_in;
      cur_ff        <= cur_in;
      prev_ff       <= prev_in;
      steps_ff      <= steps_in;
      res_status_ff <= res_status_in;
      res_value_ff  <= res_value_in;
      rsp_status_ff <= rsp_status_in;
      rsp_value_ff  <= rsp_value_in;
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_value_ff;
   assign rsp_tuser  = rsp_status_ff;

endmodule

/* src/keyed_chained_hash_table_top.sv */
// Keyed chained hash table: three pool/bucket RAMs and the sequencer.
// Depends on kcht_pkg, kcht_ram and kcht_ctrl.
//
// Usage: a request word carries an action (add, remove, lookup, pid check)
// in req_tuser and the key and value in req_tdata. Every request yields one
// response word with a status in rsp_tuser and a value in rsp_tdata.
// One request is in work at a time: after the accepting edge the sequencer
// reads the bucket head; an add then writes the new entry at once, while
// lookup, pid check and remove walk the chain, and a remove hit passes
// through a free state that returns the entry to the free list; a response
// state then raises rsp_tvalid and the sequencer goes back to the ready
// state. The next request is taken only once it is back there, and the
// chain walk through the entry RAMs visits one entry per cycle, bounded by
// the pool size.
// req_tready is high whenever no request is in work, even while a response
// waits; if the receiver stalls, the next response is held in the sequencer
// until the output register frees up.
// Reset marks every bucket empty at once through per-bucket valid flops and
// empties the pool; there is no clearing pass, and the block is ready in the
// first cycle after reset.

module keyed_chained_hash_table_top (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // Fields from bit 0: process_id[19:0], thread_id[50:20], value_in[82:51], zero pad.
   input  logic [kcht_pkg::REQ_DATA_W-1:0]  req_tdata,
   // Fields from bit 0: action[1:0].
   input  logic [kcht_pkg::ACT_W-1:0]       req_tuser,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // Fields from bit 0: value_out[31:0].
   output logic [kcht_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   // Fields from bit 0: status[1:0].
   output logic [kcht_pkg::STS_W-1:0]       rsp_tuser
);

   kcht_pkg::head_port_type            head_port;
   kcht_pkg::key_port_type             key_port;
   kcht_pkg::link_port_type            link_port;
   logic [kcht_pkg::IDX_W-1:0]         head_rd_data;
   logic [kcht_pkg::KEY_W-1:0]         key_rd_data;
   logic [kcht_pkg::IDX_W-1:0]         link_rd_data;

   kcht_ram #(
      .WIDTH (kcht_pkg::IDX_W),
      .DEPTH (kcht_pkg::BUCKETS)
   ) u_head_ram (
      .clock   (clock),
      .wr_en   (head_port.wr_en),
      .wr_addr (head_port.wr_addr),
      .wr_data (head_port.wr_data),
      .rd_en   (head_port.rd_en),
      .rd_addr (head_port.rd_addr),
      .rd_data (head_rd_data)
   );

   kcht_ram #(
      .WIDTH (kcht_pkg::KEY_W),
      .DEPTH (kcht_pkg::ENTRIES)
   ) u_key_ram (
      .clock   (clock),
      .wr_en   (key_port.wr_en),
      .wr_addr (key_port.wr_addr),
      .wr_data (key_port.wr_data),
      .rd_en   (key_port.rd_en),
      .rd_addr (key_port.rd_addr),
      .rd_data (key_rd_data)
   );

   kcht_ram #(
      .WIDTH (kcht_pkg::IDX_W),
      .DEPTH (kcht_pkg::ENTRIES)
   ) u_link_ram (
      .clock   (clock),
      .wr_en   (link_port.wr_en),
      .wr_addr (link_port.wr_addr),
      .wr_data (link_port.wr_data),
      .rd_en   (link_port.rd_en),
      .rd_addr (link_port.rd_addr),
      .rd_data (link_rd_data)
   );

   kcht_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_tdata    (req_tdata),
      .req_tuser    (req_tuser),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata),
      .rsp_tuser    (rsp_tuser),
      .head_port    (head_port),
      .head_rd_data (head_rd_data),
      .key_port     (key_port),
      .key_rd_data  (key_rd_data),
      .link_port    (link_port),
      .link_rd_data (link_rd_data)
   );

endmodule

/* tb/tb_keyed_chained_hash_table_top.sv */
// Self-checking testbench for keyed_chained_hash_table_top: a directed table, then random
// add/remove/lookup/pid-check traffic with random stalls on both streams, scored by a predictor.
// Depends on kcht_pkg and the RTL of the block.
`timescale 1ns / 1ps

module tb_keyed_chained_hash_table_top;
   import kcht_pkg::*;

   localparam int CYCLE_LIMIT = 3_000_000;
   localparam int PHASE_ITEMS = 250;
   localparam int PHASES      = 8;

   typedef struct {
      action_type       act;
      logic [PID_W-1:0] pid;
      logic [TID_W-1:0] tid;
      logic [VAL_W-1:0] val;
      bit               typed;
      status_type       status;
      logic [VAL_W-1:0] value;
   } plan_row_type;

   typedef struct {
      status_type       status;
      logic [VAL_W-1:0] value;
   } rsp_fields_type;

   typedef struct {
      logic [PID_W-1:0] pid;
      logic [TID_W-1:0] tid;
   } key_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic [ACT_W-1:0]      req_tuser = ACT_ADD;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [STS_W-1:0]      rsp_tuser;

   // Shadow copy of the table, updated as each request word is accepted.
   logic [IDX_W-1:0] shadow_head [0:BUCKETS-1];
   logic [PID_W-1:0] shadow_pid  [0:ENTRIES-1];
   logic [TID_W-1:0] shadow_tid  [0:ENTRIES-1];
   logic [VAL_W-1:0] shadow_val  [0:ENTRIES-1];
   logic [IDX_W-1:0] shadow_link [0:ENTRIES-1];
   logic [IDX_W-1:0] free_head   = NIL;
   logic [IDX_W-1:0] fresh_count = '0;

   rsp_fields_type pending_rsp [$];
   key_type        known_keys [$];
   int             mismatches = 0;
   int unsigned    cycles = 0;
   bit             steady = 1'b0;

   logic [PID_W-1:0] hot_pid [0:7] = '{20'd0, 20'd64, 20'd128, 20'd999999, 20'd999935,
                                       20'd5, 20'd69, 20'd524288};
   logic [TID_W-1:0] hot_tid [0:2] = '{31'd0, 31'd1, 31'h7FFF_FFFF};
   int               add_share [0:PHASES-1] = '{85, 85, 20, 60, 10, 85, 85, 15};

   plan_row_type directed [0:21] = '{
      '{ACT_LOOKUP, 20'd0,      31'd0,          32'h0,        1'b1, STS_MISS, 32'h0},
      '{ACT_REMOVE, 20'd999999, 31'h7FFF_FFFF,  32'hFFFF_FFFF, 1'b1, STS_MISS, 32'h0},
      '{ACT_CHECK,  20'd0,      31'd0,          32'h0,        1'b1, STS_MISS, 32'h0},
      '{ACT_ADD,    20'd0,      31'd0,          32'h0,        1'b1, STS_OK,   32'h0},
      '{ACT_ADD,    20'd999999, 31'h7FFF_FFFF,  32'hFFFF_FFFF, 1'b1, STS_OK,   32'h0},
      '{ACT_ADD,    20'd64,     31'd0,          32'h1234_5678, 1'b1, STS_OK,   32'h0},
      '{ACT_LOOKUP, 20'd999999, 31'h7FFF_FFFF,  32'h0,        1'b1, STS_OK,   32'hFFFF_FFFF},
      '{ACT_LOOKUP, 20'd0,      31'd0,          32'hFFFF_FFFF, 1'b1, STS_OK,   32'h0},
      '{ACT_CHECK,  20'd128,    31'd0,          32'h0,        1'b0, STS_OK,   32'h0},
      '{ACT_CHECK,  20'd64,     31'h7FFF_FFFF,  32'h0,        1'b0, STS_OK,   32'h0},
      '{ACT_ADD,    20'd0,      31'd0,          32'hA5A5_A5A5, 1'b0, STS_OK,   32'h0},
      '{ACT_LOOKUP, 20'd0,      31'd0,          32'h0,        1'b0, STS_OK,   32'h0},
      '{ACT_REMOVE, 20'd0,      31'd0,          32'h0,        1'b0, STS_OK,   32'h0},
      '{ACT_LOOKUP, 20'd0,      31'd0,          32'h0,        1'b0, STS_OK,   32'h0},
      '{ACT_REMOVE, 20'd64,     31'd0,          32'h0,        1'b0, STS_OK,   32'h0},
      '{ACT_ADD,    20'd5,      31'd1,          32'h5A5A_5A5A, 1'b0, STS_OK,   32'h0},
      '{ACT_LOOKUP, 20'd999999, 31'd0,          32'h0,        1'b0, STS_OK,   32'h0},
      '{ACT_CHECK,  20'd999999, 31'd1,          32'h0,        1'b0, STS_OK,   32'h0},
      '{ACT_REMOVE, 20'd0,      31'd0,          32'h0,        1'b0, STS_OK,   32'h0},
      '{ACT_REMOVE, 20'd0,      31'd0,          32'h0,        1'b0, STS_OK,   32'h0},
      '{ACT_LOOKUP, 20'd5,      31'd1,          32'h0,        1'b0, STS_OK,   32'h0},
      '{ACT_ADD,    20'd524288, 31'h4000_0000,  32'h8000_0000, 1'b0, STS_OK,   32'h0}
   };

   keyed_chained_hash_table_top u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   initial begin
      forever begin
         @(posedge clock);
         cycles++;
         if (cycles == CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
         end
      end
   end

   // Applies one request to the shadow table and returns the response it must produce.
   task automatic table_apply(input action_type act, input logic [PID_W-1:0] pid,
                              input logic [TID_W-1:0] tid, input logic [VAL_W-1:0] val,
                              output status_type status, output logic [VAL_W-1:0] value);
      logic [BKT_W-1:0] bkt;
      logic [IDX_W-1:0] cur;
      logic [IDX_W-1:0] prev;
      logic [IDX_W-1:0] hit;
      logic [IDX_W-1:0] slot;
      int               steps;
      bkt    = pid[BKT_W-1:0];
      status = STS_MISS;
      value  = '0;
      cur    = shadow_head[bkt];
      prev   = NIL;
      hit    = NIL;
      steps  = 0;
      case (act) inside
         ACT_ADD: begin
            if (free_head != NIL) begin
               slot      = free_head;
               free_head = shadow_link[slot];
            end else if (fresh_count < ENTRIES) begin
               slot = fresh_count;
               fresh_count++;
            end else begin
               slot = NIL;
            end
            if (slot != NIL) begin
               shadow_pid[slot]  = pid;
               shadow_tid[slot]  = tid;
               shadow_val[slot]  = val;
               shadow_link[slot] = shadow_head[bkt];
               shadow_head[bkt]  = slot;
               status = STS_OK;
            end else begin
               status = STS_FULL;
            end
         end
         ACT_REMOVE, ACT_LOOKUP: begin
            while (cur != NIL && steps < ENTRIES && hit == NIL) begin
               if (shadow_pid[cur] == pid && shadow_tid[cur] == tid) begin
                  hit = cur;
               end else begin
                  prev = cur;
                  cur  = shadow_link[cur];
                  steps++;
               end
            end
            if (hit != NIL) begin
               status = STS_OK;
               if (act == ACT_LOOKUP) begin
                  value = shadow_val[hit];
               end else begin
                  if (prev != NIL) shadow_link[prev] = shadow_link[hit];
                  else shadow_head[bkt] = shadow_link[hit];
                  shadow_link[hit] = free_head;
                  free_head = hit;
               end
            end
         end
         default: begin
            while (cur != NIL && steps < ENTRIES && status != STS_OK) begin
               if (shadow_pid[cur] == pid) status = STS_OK;
               cur = shadow_link[cur];
               steps++;
            end
         end
      endcase
   endtask

   task automatic send_request(input action_type act, input logic [PID_W-1:0] pid,
                               input logic [TID_W-1:0] tid, input logic [VAL_W-1:0] val,
                               input bit typed, input status_type status,
                               input logic [VAL_W-1:0] value);
      int               gap;
      status_type       calc_status;
      logic [VAL_W-1:0] calc_value;
      rsp_fields_type   rsp;
      gap = steady ? 0 : $urandom_range(0, 17);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= act;
      req_tdata  <= REQ_DATA_W'({val, tid, pid});
      do @(posedge clock); while (!req_tready);
      table_apply(act, pid, tid, val, calc_status, calc_value);
      rsp.status = typed ? status : calc_status;
      rsp.value  = typed ? value : calc_value;
      pending_rsp.push_back(rsp);
   endtask

   function automatic key_type fresh_key();
      key_type k;
      k.pid = ($urandom_range(0, 3) == 0) ? hot_pid[$urandom_range(0, 7)]
                                           : PID_W'($urandom_range(0, 999999));
      k.tid = ($urandom_range(0, 2) == 0) ? hot_tid[$urandom_range(0, 2)]
                                           : TID_W'($urandom_range(0, 32'h7FFF_FFFF));
      return k;
   endfunction

   // Reuses an added key with chance reuse_pct, so removes and lookups hit and duplicates pile up.
   function automatic key_type pick_key(input int reuse_pct);
      if (known_keys.size() > 0 && $urandom_range(0, 99) < reuse_pct)
         return known_keys[$urandom_range(0, known_keys.size() - 1)];
      return fresh_key();
   endfunction

   initial begin
      rsp_fields_type exp_rsp;
      wait (!reset);
      forever begin
         int stall;
         stall = steady ? 0 : $urandom_range(0, 17);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         if (pending_rsp.size() == 0) begin
            $error("unexpected response word: status %0d, value_out %h", rsp_tuser, rsp_tdata);
            mismatches++;
         end else begin
            exp_rsp = pending_rsp.pop_front();
            if (rsp_tuser !== exp_rsp.status) begin
               $error("status: expected %0d, got %0d", exp_rsp.status, rsp_tuser);
               mismatches++;
            end
            if (rsp_tdata !== exp_rsp.value) begin
               $error("value_out: expected %h, got %h", exp_rsp.value, rsp_tdata);
               mismatches++;
            end
         end
      end
   end

   initial begin
      action_type act;
      key_type    k;
      int         pick;
      for (int b = 0; b < BUCKETS; b++) shadow_head[b] = NIL;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      foreach (directed[i]) begin
         send_request(directed[i].act, directed[i].pid, directed[i].tid, directed[i].val,
                      directed[i].typed, directed[i].status, directed[i].value);
      end

      // Each phase has its own add share: some fill the pool past full, others drain it.
      for (int p = 0; p < PHASES; p++) begin
         steady = ($urandom_range(0, 3) == 0);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < add_share[p]) begin
               act = ACT_ADD;
               k   = pick_key(40);
               known_keys.push_back(k);
               if (known_keys.size() > 128) void'(known_keys.pop_front());
            end else begin
               pick = $urandom_range(0, 9);
               act  = (pick < 5) ? ACT_REMOVE : (pick < 8) ? ACT_LOOKUP : ACT_CHECK;
               k    = pick_key(80);
            end
            send_request(act, k.pid, k.tid, VAL_W'($urandom()), 1'b0, STS_OK, '0);
         end
      end
      req_tvalid <= 1'b0;
      steady = 1'b0;

      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (ENTRIES + 16) @(posedge clock);
      if (mismatches == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
